// ----- hw/rtl/med_pkg.sv -----
// Package for the motor effort to DAC mapper.
// Holds widths, constants, register indexes and the sequencer state type.
// No dependencies.
package med_pkg;

    localparam int unsigned CFG_W              = 17;
    localparam int unsigned CFG_N              = 6;
    localparam int unsigned CMD_W              = 18;
    localparam int unsigned DAC_W              = 10;
    localparam int unsigned DAC_FS_W           = 16;
    localparam int unsigned DAC_FULL_SCALE_DEF = 1023;
    localparam int unsigned EFFORT_FULL        = 100000;
    localparam int unsigned NUM_W              = 34;
    localparam int unsigned CNT_W              = 6;
    localparam int unsigned ADDR_W             = 5;
    localparam int unsigned APB_W              = 32;

    // floor(p / 100000) == floor(floor(p / 32) * DAC_RECIP / 2**DAC_RECIP_SH)
    // for every p below 2**33
    localparam logic [27:0] DAC_RECIP    = 28'd175921861;
    localparam int unsigned DAC_RECIP_SH = 39;

    localparam logic KIND_DRIVE = 1'b0;
    localparam logic KIND_OFF   = 1'b1;

    localparam logic [2:0] REG_CMD_LOW     = 3'd0;
    localparam logic [2:0] REG_CMD_KNEE    = 3'd1;
    localparam logic [2:0] REG_CMD_HIGH    = 3'd2;
    localparam logic [2:0] REG_EFFORT_LOW  = 3'd3;
    localparam logic [2:0] REG_EFFORT_KNEE = 3'd4;
    localparam logic [2:0] REG_EFFORT_HIGH = 3'd5;

    localparam logic [CFG_W-1:0] RST_CMD_LOW     = 17'd0;
    localparam logic [CFG_W-1:0] RST_CMD_KNEE    = 17'd1;
    localparam logic [CFG_W-1:0] RST_CMD_HIGH    = 17'd100000;
    localparam logic [CFG_W-1:0] RST_EFFORT_LOW  = 17'd0;
    localparam logic [CFG_W-1:0] RST_EFFORT_KNEE = 17'd32100;
    localparam logic [CFG_W-1:0] RST_EFFORT_HIGH = 17'd100000;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLAMP,
        S_SETUP,
        S_MUL,
        S_DIV,
        S_SAT,
        S_MUL2,
        S_MUL3,
        S_EMIT_SET,
        S_EMIT_FIN,
        S_EMIT_OFF
    } t_state;

endpackage

// ----- hw/rtl/motor_effort_to_dac_mapper_unit.sv -----
// Top level of the motor effort to DAC mapper: APB registers, sequencer,
// one shared multiplier and one restoring divider.
// Depends on med_pkg.
//
//  channel   | handshake                   | payload
//  ----------+-----------------------------+---------------------------------
//  input     | i_in_valid / o_in_stall     | i_kind, i_command_value
//  output    | o_out_valid / i_out_stall   | o_dac_code .. o_last
//  config    | psel penable pwrite pready  | paddr, pwdata, prdata
//
// An off word passes S_EMIT_OFF to the output register. A drive word passes
// S_CLAMP, S_SETUP, S_MUL, the bit-serial divider (S_DIV, skipped for a
// zero-width segment), S_SAT and DAC scaling by reciprocal multiplication
// (S_MUL2, S_MUL3); a settle word adds S_EMIT_SET. Output stalls hold the
// emit states. The input stalls for the whole item; the output register
// holds a result while the next word is worked on. Reset is synchronous.
module motor_effort_to_dac_mapper_unit #(
    parameter int unsigned DAC_FULL_SCALE = med_pkg::DAC_FULL_SCALE_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_kind,
    input  logic signed [med_pkg::CMD_W-1:0]  i_command_value,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [med_pkg::DAC_W-1:0]         o_dac_code,
    output logic                              o_direction,
    output logic                              o_enable,
    output logic                              o_settle_pause,
    output logic [med_pkg::CFG_W-1:0]         o_mapped_effort,
    output logic                              o_last,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [med_pkg::ADDR_W-1:0]        paddr,
    input  logic [med_pkg::APB_W-1:0]         pwdata,
    output logic [med_pkg::APB_W-1:0]         prdata,
    output logic                              pready
);

    localparam int unsigned NUM_W = med_pkg::NUM_W;
    localparam int unsigned CFG_W = med_pkg::CFG_W;
    localparam logic [med_pkg::DAC_FS_W-1:0] FS = DAC_FULL_SCALE[med_pkg::DAC_FS_W-1:0];
    localparam logic [CFG_W-1:0] EFF_FULL = med_pkg::EFFORT_FULL[CFG_W-1:0];
    localparam logic signed [35:0] EFF_FULL_S = 36'sd100000;

    med_pkg::t_state r_state, n_state;

    logic [CFG_W-1:0] r_cfg [med_pkg::CFG_N];
    logic             r_last_dir;
    logic             r_dir;
    logic             r_settle;
    logic [17:0]      r_x;
    logic [CFG_W-1:0] r_xc;
    logic signed [17:0] r_dx, r_dy, r_span;
    logic [CFG_W-1:0] r_ya, r_yb;
    logic             r_zero;
    logic [NUM_W-1:0] r_num;
    logic [CFG_W-1:0] r_rem;
    logic [CFG_W-1:0] r_den;
    logic             r_neg;
    logic [med_pkg::CNT_W-1:0] r_count;
    logic [CFG_W-1:0] r_eff;

    logic                     r_o_valid;
    logic [med_pkg::DAC_W-1:0] r_o_dac;
    logic                     r_o_dir, r_o_en, r_o_pause, r_o_last;
    logic [CFG_W-1:0]         r_o_eff;

    logic                 cfg_wr;
    logic                 out_free;
    logic                 out_load;
    logic                 div_done;
    logic signed [17:0]   cmd_neg;
    logic                 cmd_dir;
    logic signed [28:0]   mul_a, mul_b;
    logic signed [57:0]   prod;
    logic signed [57:0]   prod_abs;
    logic signed [17:0]   span_abs;
    logic [17:0]          rem_sh;
    logic                 rem_ge;
    logic [17:0]          rem_sub;
    logic signed [35:0]   q_s;
    logic signed [35:0]   sum_s;
    logic [CFG_W-1:0]     eff_sat;
    logic                 seg_one;
    logic [CFG_W-1:0]     xa, xb, ya, yb;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign out_free = !r_o_valid || !i_out_stall;
    assign div_done = (r_count == med_pkg::CNT_W'(NUM_W - 1));

    always_comb begin
        case (paddr[4:2])
            med_pkg::REG_CMD_LOW:     prdata = {15'd0, r_cfg[med_pkg::REG_CMD_LOW]};
            med_pkg::REG_CMD_KNEE:    prdata = {15'd0, r_cfg[med_pkg::REG_CMD_KNEE]};
            med_pkg::REG_CMD_HIGH:    prdata = {15'd0, r_cfg[med_pkg::REG_CMD_HIGH]};
            med_pkg::REG_EFFORT_LOW:  prdata = {15'd0, r_cfg[med_pkg::REG_EFFORT_LOW]};
            med_pkg::REG_EFFORT_KNEE: prdata = {15'd0, r_cfg[med_pkg::REG_EFFORT_KNEE]};
            med_pkg::REG_EFFORT_HIGH: prdata = {15'd0, r_cfg[med_pkg::REG_EFFORT_HIGH]};
            default:                  prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg[med_pkg::REG_CMD_LOW]     <= med_pkg::RST_CMD_LOW;
            r_cfg[med_pkg::REG_CMD_KNEE]    <= med_pkg::RST_CMD_KNEE;
            r_cfg[med_pkg::REG_CMD_HIGH]    <= med_pkg::RST_CMD_HIGH;
            r_cfg[med_pkg::REG_EFFORT_LOW]  <= med_pkg::RST_EFFORT_LOW;
            r_cfg[med_pkg::REG_EFFORT_KNEE] <= med_pkg::RST_EFFORT_KNEE;
            r_cfg[med_pkg::REG_EFFORT_HIGH] <= med_pkg::RST_EFFORT_HIGH;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                med_pkg::REG_CMD_LOW,
                med_pkg::REG_CMD_KNEE,
                med_pkg::REG_CMD_HIGH,
                med_pkg::REG_EFFORT_LOW,
                med_pkg::REG_EFFORT_KNEE,
                med_pkg::REG_EFFORT_HIGH: r_cfg[paddr[4:2]] <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer
    always_comb begin
        n_state  = r_state;
        out_load = 1'b0;
        case (r_state)
            med_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_kind == med_pkg::KIND_OFF) ? med_pkg::S_EMIT_OFF
                                                            : med_pkg::S_CLAMP;
                end
            end
            med_pkg::S_CLAMP: n_state = med_pkg::S_SETUP;
            med_pkg::S_SETUP: n_state = med_pkg::S_MUL;
            med_pkg::S_MUL:   n_state = r_zero ? med_pkg::S_SAT : med_pkg::S_DIV;
            med_pkg::S_DIV: begin
                if (div_done) begin
                    n_state = med_pkg::S_SAT;
                end
            end
            med_pkg::S_SAT:  n_state = med_pkg::S_MUL2;
            med_pkg::S_MUL2: n_state = med_pkg::S_MUL3;
            med_pkg::S_MUL3: n_state = r_settle ? med_pkg::S_EMIT_SET : med_pkg::S_EMIT_FIN;
            med_pkg::S_EMIT_SET: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = med_pkg::S_EMIT_FIN;
                end
            end
            med_pkg::S_EMIT_FIN, med_pkg::S_EMIT_OFF: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = med_pkg::S_IDLE;
                end
            end
            default: n_state = med_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= med_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != med_pkg::S_IDLE);

    // datapath helpers
    assign cmd_neg = -i_command_value;
    assign cmd_dir = !i_command_value[17] && (i_command_value != '0);

    assign seg_one = (r_xc < r_cfg[med_pkg::REG_CMD_KNEE]);
    assign xa = seg_one ? r_cfg[med_pkg::REG_CMD_LOW]     : r_cfg[med_pkg::REG_CMD_KNEE];
    assign xb = seg_one ? r_cfg[med_pkg::REG_CMD_KNEE]    : r_cfg[med_pkg::REG_CMD_HIGH];
    assign ya = seg_one ? r_cfg[med_pkg::REG_EFFORT_LOW]  : r_cfg[med_pkg::REG_EFFORT_KNEE];
    assign yb = seg_one ? r_cfg[med_pkg::REG_EFFORT_KNEE] : r_cfg[med_pkg::REG_EFFORT_HIGH];

    always_comb begin
        case (r_state)
            med_pkg::S_MUL2: begin
                mul_a = $signed({12'd0, EFF_FULL - r_eff});
                mul_b = $signed({13'd0, FS});
            end
            med_pkg::S_MUL3: begin
                // scaled product divided by 32 times reciprocal of 3125
                mul_a = $signed({1'b0, r_num[32:5]});
                mul_b = $signed({1'b0, med_pkg::DAC_RECIP});
            end
            default: begin
                mul_a = $signed({{11{r_dx[17]}}, r_dx});
                mul_b = $signed({{11{r_dy[17]}}, r_dy});
            end
        endcase
    end

    assign prod     = mul_a * mul_b;
    assign prod_abs = prod[57] ? -prod : prod;
    assign span_abs = r_span[17] ? -r_span : r_span;

    assign rem_sh  = {r_rem, r_num[NUM_W-1]};
    assign rem_ge  = (rem_sh >= {1'b0, r_den});
    assign rem_sub = rem_sh - {1'b0, r_den};

    assign q_s   = r_neg ? -$signed({2'b00, r_num}) : $signed({2'b00, r_num});
    assign sum_s = r_zero ? $signed({19'd0, r_yb}) : (q_s + $signed({19'd0, r_ya}));

    always_comb begin
        if (sum_s < 36'sd0) begin
            eff_sat = '0;
        end else if (sum_s > EFF_FULL_S) begin
            eff_sat = EFF_FULL;
        end else begin
            eff_sat = sum_s[CFG_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_dir <= 1'b0;
        end else if (r_state == med_pkg::S_IDLE && i_in_valid
                     && i_kind == med_pkg::KIND_DRIVE) begin
            r_last_dir <= cmd_dir;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            med_pkg::S_IDLE: begin
                r_dir    <= cmd_dir;
                r_settle <= (cmd_dir != r_last_dir);
                r_x      <= i_command_value[17] ? cmd_neg : i_command_value;
            end
            med_pkg::S_CLAMP: begin
                if (r_x < {1'b0, r_cfg[med_pkg::REG_CMD_LOW]}) begin
                    r_xc <= r_cfg[med_pkg::REG_CMD_LOW];
                end else if (r_x > {1'b0, r_cfg[med_pkg::REG_CMD_HIGH]}) begin
                    r_xc <= r_cfg[med_pkg::REG_CMD_HIGH];
                end else begin
                    r_xc <= r_x[CFG_W-1:0];
                end
            end
            med_pkg::S_SETUP: begin
                r_dx   <= $signed({1'b0, r_xc}) - $signed({1'b0, xa});
                r_dy   <= $signed({1'b0, yb}) - $signed({1'b0, ya});
                r_span <= $signed({1'b0, xb}) - $signed({1'b0, xa});
                r_zero <= (xb == xa);
                r_ya   <= ya;
                r_yb   <= yb;
            end
            med_pkg::S_MUL: begin
                r_num   <= prod_abs[NUM_W-1:0];
                r_neg   <= prod[57] ^ r_span[17];
                r_rem   <= '0;
                r_count <= '0;
                r_den   <= span_abs[CFG_W-1:0];
            end
            med_pkg::S_DIV: begin
                r_rem   <= rem_ge ? rem_sub[CFG_W-1:0] : rem_sh[CFG_W-1:0];
                r_num   <= {r_num[NUM_W-2:0], rem_ge};
                r_count <= r_count + 1'b1;
            end
            med_pkg::S_SAT: begin
                r_eff <= eff_sat;
            end
            med_pkg::S_MUL2: begin
                r_num <= prod[NUM_W-1:0];
            end
            med_pkg::S_MUL3: begin
                r_num <= NUM_W'(prod[57:med_pkg::DAC_RECIP_SH]);
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_load) begin
            r_o_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            case (r_state)
                med_pkg::S_EMIT_SET: begin
                    r_o_dac   <= FS[med_pkg::DAC_W-1:0];
                    r_o_dir   <= r_dir;
                    r_o_en    <= 1'b1;
                    r_o_pause <= 1'b1;
                    r_o_eff   <= '0;
                    r_o_last  <= 1'b0;
                end
                med_pkg::S_EMIT_FIN: begin
                    r_o_dac   <= r_num[med_pkg::DAC_W-1:0];
                    r_o_dir   <= r_dir;
                    r_o_en    <= 1'b1;
                    r_o_pause <= 1'b0;
                    r_o_eff   <= r_eff;
                    r_o_last  <= 1'b1;
                end
                default: begin
                    r_o_dac   <= FS[med_pkg::DAC_W-1:0];
                    r_o_dir   <= r_last_dir;
                    r_o_en    <= 1'b0;
                    r_o_pause <= 1'b0;
                    r_o_eff   <= '0;
                    r_o_last  <= 1'b1;
                end
            endcase
        end
    end

    assign o_out_valid     = r_o_valid;
    assign o_dac_code      = r_o_dac;
    assign o_direction     = r_o_dir;
    assign o_enable        = r_o_en;
    assign o_settle_pause  = r_o_pause;
    assign o_mapped_effort = r_o_eff;
    assign o_last          = r_o_last;

    a_settle_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_settle_pause |-> !o_last && o_enable && o_mapped_effort == '0)
        else $error("settle word carries wrong flags");

    a_off_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_enable |-> o_last && !o_settle_pause && o_mapped_effort == '0)
        else $error("off word carries wrong fields");

    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == med_pkg::S_DIV |-> r_count < med_pkg::CNT_W'(NUM_W))
        else $error("divider ran past its last step");

    a_effort_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_mapped_effort <= EFF_FULL)
        else $error("mapped effort above full scale");

endmodule

// ----- tb/sv/dac_word_checker.sv -----
// Checker for the motor effort to DAC mapper: follows register writes,
// predicts the output words of every accepted input word and compares them.
// Depends on med_pkg.
module dac_word_checker #(
    parameter int unsigned DAC_FULL_SCALE = med_pkg::DAC_FULL_SCALE_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  logic                              i_in_stall,
    input  logic                              i_off,
    input  logic signed [med_pkg::CMD_W-1:0]  i_command_value,
    input  logic                              i_out_valid,
    input  logic                              i_out_stall,
    input  logic [med_pkg::DAC_W-1:0]         i_dac_code,
    input  logic                              i_direction,
    input  logic                              i_enable,
    input  logic                              i_settle_pause,
    input  logic [med_pkg::CFG_W-1:0]         i_mapped_effort,
    input  logic                              i_last,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic                              pready,
    input  logic [med_pkg::ADDR_W-1:0]        paddr,
    input  logic [med_pkg::APB_W-1:0]         pwdata,
    output int                                o_fail_count,
    output int                                o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [med_pkg::DAC_W-1:0] dac_code;
        logic                      direction;
        logic                      enable;
        logic                      settle_pause;
        logic [med_pkg::CFG_W-1:0] mapped_effort;
        logic                      last;
    } t_dac_word;

    t_dac_word                 expected_words[$];
    logic [med_pkg::CFG_W-1:0] map_reg [med_pkg::CFG_N];
    logic                      dir_state;

    function automatic longint lerp_segment(longint x, longint xa, longint xb,
                                            longint ya, longint yb);
        if (xb == xa) begin
            return yb;
        end
        return (x - xa) * (yb - ya) / (xb - xa) + ya;
    endfunction

    function automatic t_dac_word make_word(logic [med_pkg::DAC_W-1:0] dac, logic dir,
                                            logic en, logic pause,
                                            logic [med_pkg::CFG_W-1:0] eff, logic lst);
        t_dac_word w;
        w.dac_code      = dac;
        w.direction     = dir;
        w.enable        = en;
        w.settle_pause  = pause;
        w.mapped_effort = eff;
        w.last          = lst;
        return w;
    endfunction

    function void predict_words(logic off, logic signed [med_pkg::CMD_W-1:0] cmd);
        longint c_low, c_knee, c_high, e_low, e_knee, e_high;
        longint mag, eff, dac, full;
        logic   new_dir;
        full   = med_pkg::EFFORT_FULL;
        c_low  = longint'(map_reg[med_pkg::REG_CMD_LOW]);
        c_knee = longint'(map_reg[med_pkg::REG_CMD_KNEE]);
        c_high = longint'(map_reg[med_pkg::REG_CMD_HIGH]);
        e_low  = longint'(map_reg[med_pkg::REG_EFFORT_LOW]);
        e_knee = longint'(map_reg[med_pkg::REG_EFFORT_KNEE]);
        e_high = longint'(map_reg[med_pkg::REG_EFFORT_HIGH]);
        if (off == med_pkg::KIND_OFF) begin
            expected_words.push_back(make_word(med_pkg::DAC_W'(DAC_FULL_SCALE), dir_state,
                                               1'b0, 1'b0, '0, 1'b1));
            return;
        end
        new_dir = (cmd > 0);
        if (new_dir != dir_state) begin
            expected_words.push_back(make_word(med_pkg::DAC_W'(DAC_FULL_SCALE), new_dir,
                                               1'b1, 1'b1, '0, 1'b0));
        end
        dir_state = new_dir;
        mag = longint'(cmd);
        if (mag < 0) begin
            mag = -mag;
        end
        if (mag < c_low) begin
            mag = c_low;
        end else if (mag > c_high) begin
            mag = c_high;
        end
        if (mag < c_knee) begin
            eff = lerp_segment(mag, c_low, c_knee, e_low, e_knee);
        end else begin
            eff = lerp_segment(mag, c_knee, c_high, e_knee, e_high);
        end
        if (eff < 0) begin
            eff = 0;
        end
        if (eff > full) begin
            eff = full;
        end
        dac = longint'(DAC_FULL_SCALE) * (full - eff) / full;
        expected_words.push_back(make_word(med_pkg::DAC_W'(dac), new_dir, 1'b1, 1'b0,
                                           med_pkg::CFG_W'(eff), 1'b1));
    endfunction

    function void check_field(string name, longint want, longint got);
        if (want != got) begin
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
            o_fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_dac_word want;
        if (!i_rst_n) begin
            map_reg[med_pkg::REG_CMD_LOW]     = med_pkg::RST_CMD_LOW;
            map_reg[med_pkg::REG_CMD_KNEE]    = med_pkg::RST_CMD_KNEE;
            map_reg[med_pkg::REG_CMD_HIGH]    = med_pkg::RST_CMD_HIGH;
            map_reg[med_pkg::REG_EFFORT_LOW]  = med_pkg::RST_EFFORT_LOW;
            map_reg[med_pkg::REG_EFFORT_KNEE] = med_pkg::RST_EFFORT_KNEE;
            map_reg[med_pkg::REG_EFFORT_HIGH] = med_pkg::RST_EFFORT_HIGH;
            dir_state = 1'b0;
            expected_words.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_words.size() == 0) begin
                    $display("%0t: extra word dac %0d dir %0b en %0b pause %0b eff %0d last %0b",
                             $time, i_dac_code, i_direction, i_enable, i_settle_pause,
                             i_mapped_effort, i_last);
                    o_fail_count++;
                end else begin
                    want = expected_words.pop_front();
                    check_field("dac_code", want.dac_code, i_dac_code);
                    check_field("direction", want.direction, i_direction);
                    check_field("enable", want.enable, i_enable);
                    check_field("settle_pause", want.settle_pause, i_settle_pause);
                    check_field("mapped_effort", want.mapped_effort, i_mapped_effort);
                    check_field("last", want.last, i_last);
                end
            end
            if (psel && penable && pwrite && pready
                && paddr[med_pkg::ADDR_W-1:2] < med_pkg::CFG_N) begin
                map_reg[paddr[med_pkg::ADDR_W-1:2]] = pwdata[med_pkg::CFG_W-1:0];
            end
            if (i_in_valid && !i_in_stall) begin
                predict_words(i_off, i_command_value);
            end
        end
        o_pending = expected_words.size();
    end

endmodule

// ----- tb/sv/motor_effort_to_dac_mapper_unit_test.sv -----
// Testbench top for the motor effort to DAC mapper: clock, reset, register
// programming, command stimulus with bursts and output stalls, and verdict.
// Depends on med_pkg, dac_word_checker and motor_effort_to_dac_mapper_unit.
module motor_effort_to_dac_mapper_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned DAC_FS      = med_pkg::DAC_FULL_SCALE_DEF;
    localparam int          PHASES      = 10;
    localparam int          PHASE_WORDS = 185;

    typedef enum int {
        MAP_ORDERED,
        MAP_FLAT_FIRST,
        MAP_FLAT_SECOND,
        MAP_CROSSED,
        MAP_SHUFFLED,
        MAP_ZERO,
        MAP_FULL,
        MAP_WILD,
        MAP_DEFAULT
    } t_map_shape;

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              in_valid;
    logic                              in_stall;
    logic                              kind;
    logic signed [med_pkg::CMD_W-1:0]  command_value;
    logic                              out_valid;
    logic                              out_stall = 1'b0;
    logic [med_pkg::DAC_W-1:0]         dac_code;
    logic                              direction;
    logic                              enable;
    logic                              settle_pause;
    logic [med_pkg::CFG_W-1:0]         mapped_effort;
    logic                              last;
    logic                              psel;
    logic                              penable;
    logic                              pwrite;
    logic [med_pkg::ADDR_W-1:0]        paddr;
    logic [med_pkg::APB_W-1:0]         pwdata;
    logic [med_pkg::APB_W-1:0]         prdata;
    logic                              pready;
    int                                fail_count;
    int                                pending;

    int   stall_mode  = 0;
    int   stall_hold  = 0;
    int   stall_tick  = 0;
    logic stall_level = 1'b0;

    motor_effort_to_dac_mapper_unit #(.DAC_FULL_SCALE(DAC_FS)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_kind(kind), .i_command_value(command_value),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_dac_code(dac_code), .o_direction(direction), .o_enable(enable),
        .o_settle_pause(settle_pause), .o_mapped_effort(mapped_effort), .o_last(last),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    dac_word_checker #(.DAC_FULL_SCALE(DAC_FS)) u_check (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall),
        .i_off(kind), .i_command_value(command_value),
        .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_dac_code(dac_code), .i_direction(direction), .i_enable(enable),
        .i_settle_pause(settle_pause), .i_mapped_effort(mapped_effort), .i_last(last),
        .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
        .paddr(paddr), .pwdata(pwdata),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        if (stall_tick == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_tick = $urandom_range(50, 400);
        end else begin
            stall_tick--;
        end
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            default: begin
                if (stall_hold == 0) begin
                    stall_level = ~stall_level;
                    stall_hold  = $urandom_range(1, 24);
                end else begin
                    stall_hold--;
                end
                out_stall <= stall_level;
            end
        endcase
    end

    task automatic push_word(logic k, logic signed [med_pkg::CMD_W-1:0] value);
        @(negedge i_clk);
        in_valid      <= 1'b1;
        kind          <= k;
        command_value <= value;
        do @(posedge i_clk); while (in_stall);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [med_pkg::CFG_W-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= med_pkg::APB_W'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial begin : stimulus
        int                                directed_cmd [13];
        logic                              directed_kind [13];
        logic [med_pkg::CFG_W-1:0]         map_val [med_pkg::CFG_N];
        t_map_shape                        shape;
        int                                burst_left;
        int                                gap;
        int                                mag;
        int                                pick;
        logic                              k;
        logic signed [med_pkg::CMD_W-1:0]  value;

        in_valid      = 1'b0;
        kind          = med_pkg::KIND_DRIVE;
        command_value = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        i_rst_n       = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        directed_cmd  = '{0, 1, 131071, -5, -1, -131072, 7, 100000, 100001, 2,
                          -100000, 0, -1};
        directed_kind = '{med_pkg::KIND_DRIVE, med_pkg::KIND_DRIVE, med_pkg::KIND_DRIVE,
                          med_pkg::KIND_OFF, med_pkg::KIND_DRIVE, med_pkg::KIND_DRIVE,
                          med_pkg::KIND_OFF, med_pkg::KIND_DRIVE, med_pkg::KIND_DRIVE,
                          med_pkg::KIND_DRIVE, med_pkg::KIND_DRIVE, med_pkg::KIND_DRIVE,
                          med_pkg::KIND_OFF};
        for (int i = 0; i < 13; i++) begin
            push_word(directed_kind[i], med_pkg::CMD_W'(directed_cmd[i]));
        end
        wait_drained();

        for (int p = 0; p < PHASES; p++) begin
            shape = (p < 9) ? t_map_shape'(p) : t_map_shape'($urandom_range(0, 8));
            case (shape)
                MAP_ORDERED, MAP_FLAT_FIRST, MAP_FLAT_SECOND: begin
                    map_val[med_pkg::REG_CMD_LOW]     = $urandom_range(0, 5000);
                    map_val[med_pkg::REG_CMD_KNEE]    =
                        $urandom_range(map_val[med_pkg::REG_CMD_LOW], 40000);
                    map_val[med_pkg::REG_CMD_HIGH]    =
                        $urandom_range(map_val[med_pkg::REG_CMD_KNEE], 100000);
                    map_val[med_pkg::REG_EFFORT_LOW]  = $urandom_range(0, 20000);
                    map_val[med_pkg::REG_EFFORT_KNEE] =
                        $urandom_range(map_val[med_pkg::REG_EFFORT_LOW], 60000);
                    map_val[med_pkg::REG_EFFORT_HIGH] =
                        $urandom_range(map_val[med_pkg::REG_EFFORT_KNEE], 100000);
                    if (shape == MAP_FLAT_FIRST) begin
                        map_val[med_pkg::REG_CMD_KNEE] = map_val[med_pkg::REG_CMD_LOW];
                    end
                    if (shape == MAP_FLAT_SECOND) begin
                        map_val[med_pkg::REG_CMD_HIGH] = map_val[med_pkg::REG_CMD_KNEE];
                    end
                end
                MAP_CROSSED: begin
                    map_val[med_pkg::REG_CMD_HIGH]    = $urandom_range(0, 50000);
                    map_val[med_pkg::REG_CMD_LOW]     =
                        $urandom_range(map_val[med_pkg::REG_CMD_HIGH] + 1, 100000);
                    map_val[med_pkg::REG_CMD_KNEE]    = $urandom_range(0, 100000);
                    map_val[med_pkg::REG_EFFORT_LOW]  = $urandom_range(0, 100000);
                    map_val[med_pkg::REG_EFFORT_KNEE] = $urandom_range(0, 100000);
                    map_val[med_pkg::REG_EFFORT_HIGH] = $urandom_range(0, 100000);
                end
                MAP_SHUFFLED: begin
                    foreach (map_val[r]) map_val[r] = $urandom_range(0, 100000);
                end
                MAP_ZERO: begin
                    foreach (map_val[r]) map_val[r] = '0;
                end
                MAP_FULL: begin
                    foreach (map_val[r]) map_val[r] = '1;
                end
                MAP_WILD: begin
                    foreach (map_val[r]) map_val[r] = $urandom_range(0, 131071);
                end
                default: begin
                    map_val[med_pkg::REG_CMD_LOW]     = med_pkg::RST_CMD_LOW;
                    map_val[med_pkg::REG_CMD_KNEE]    = med_pkg::RST_CMD_KNEE;
                    map_val[med_pkg::REG_CMD_HIGH]    = med_pkg::RST_CMD_HIGH;
                    map_val[med_pkg::REG_EFFORT_LOW]  = med_pkg::RST_EFFORT_LOW;
                    map_val[med_pkg::REG_EFFORT_KNEE] = med_pkg::RST_EFFORT_KNEE;
                    map_val[med_pkg::REG_EFFORT_HIGH] = med_pkg::RST_EFFORT_HIGH;
                end
            endcase
            for (int r = 0; r < med_pkg::CFG_N; r++) begin
                write_reg(3'(r), map_val[r]);
            end

            burst_left = 0;
            for (int n = 0; n < PHASE_WORDS; n++) begin
                if (burst_left == 0) begin
                    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    if (gap > 0) begin
                        @(negedge i_clk);
                        in_valid <= 1'b0;
                        repeat (gap - 1) @(negedge i_clk);
                    end
                    burst_left = $urandom_range(1, 16);
                end
                burst_left--;

                k    = ($urandom_range(0, 99) < 15) ? med_pkg::KIND_OFF : med_pkg::KIND_DRIVE;
                pick = $urandom_range(0, 99);
                if (pick < 30) begin
                    mag = $urandom_range(0, 110000);
                end else if (pick < 55) begin
                    mag = int'(map_val[$urandom_range(med_pkg::REG_CMD_LOW,
                                                      med_pkg::REG_CMD_HIGH)])
                          + int'($urandom_range(0, 6)) - 3;
                end else if (pick < 90) begin
                    mag = $urandom_range(0, 3);
                end else begin
                    mag = $urandom_range(0, 1) ? 100000 : 131071;
                end
                if (mag < 0) begin
                    mag = 0;
                end
                if (mag > 131071) begin
                    mag = 131071;
                end
                if (pick >= 75 && pick < 90) begin
                    value = med_pkg::CMD_W'($urandom());
                end else if (pick >= 97) begin
                    value = -med_pkg::CMD_W'(131072);
                end else begin
                    value = $urandom_range(0, 1) ? med_pkg::CMD_W'(-mag)
                                                 : med_pkg::CMD_W'(mag);
                end
                push_word(k, value);
            end
            wait_drained();
        end

        repeat (100) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/med_pkg.sv
hw/rtl/motor_effort_to_dac_mapper_unit.sv
tb/sv/dac_word_checker.sv
tb/sv/motor_effort_to_dac_mapper_unit_test.sv
